@@ rtl/lpm_pkg.sv @@
package lpm_pkg;

   localparam int IDX_W         = 4;
   localparam int ADDR_W        = 32;
   localparam int DEPTH_DEFAULT = 16;
   localparam int QUEUE_DEPTH   = 2;
   localparam int MAX_SLOTS     = 1 << IDX_W;

   typedef enum logic [1:0] {
      OP_LOOKUP,
      OP_WRITE,
      OP_DROP
   } lpm_op_type;

   // One classified item. data carries the lookup address or the written destination.
   typedef struct packed {
      lpm_op_type          op;
      logic [IDX_W-1:0]    index;
      logic [ADDR_W-1:0]   data;
      logic [ADDR_W-1:0]   mask;
      logic                valid;
   } lpm_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } lpm_q_status_type;

   typedef struct packed {
      logic                valid;
      logic [ADDR_W-1:0]   mask;
      logic [IDX_W-1:0]    index;
   } lpm_cand_type;

   // Only slots reachable by a 4-bit index are ever written.
   function automatic int slot_count(input int depth);
      int n;
      n = (depth < MAX_SLOTS) ? depth : MAX_SLOTS;
      return n;
   endfunction

   // Valid b wins if a is invalid or b's mask is strictly longer; lower index wins ties.
   function automatic lpm_cand_type better(input lpm_cand_type a, input lpm_cand_type b);
      lpm_cand_type r;
      r = a;
      if (b.valid && (!a.valid || (b.mask > a.mask))) begin
         r = b;
      end
      return r;
   endfunction

endpackage

@@ rtl/lpm_front.sv @@
module lpm_front #(
   parameter int TABLE_DEPTH = lpm_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_type,
   input  logic [lpm_pkg::IDX_W-1:0]     req_entry_index,
   input  logic [lpm_pkg::ADDR_W-1:0]    req_entry_dest,
   input  logic [lpm_pkg::ADDR_W-1:0]    req_entry_mask,
   input  logic                          req_entry_valid,
   input  logic [lpm_pkg::ADDR_W-1:0]    req_lookup_addr,
   output logic                          push,
   output lpm_pkg::lpm_cmd_type          push_cmd,
   input  lpm_pkg::lpm_q_status_type     q_status
);

   localparam int SLOTS = lpm_pkg::slot_count(TABLE_DEPTH);
   localparam int CMP_W = lpm_pkg::IDX_W + 1;

   logic                  valid_ff, valid_in;
   lpm_pkg::lpm_cmd_type  cmd_ff, cmd_in;
   lpm_pkg::lpm_cmd_type  cmd_new;
   logic                  accept;
   logic                  in_range;

   assign req_stall = valid_ff && q_status.full;
   assign accept    = req_valid && !req_stall;
   assign push      = valid_ff && !q_status.full;
   assign push_cmd  = cmd_ff;

   assign in_range = {1'b0, req_entry_index} < CMP_W'(SLOTS);

   always_comb begin
      cmd_new.index = req_entry_index;
      cmd_new.mask  = req_entry_mask;
      cmd_new.valid = req_entry_valid;
      if (req_type) begin
         cmd_new.op   = in_range ? lpm_pkg::OP_WRITE : lpm_pkg::OP_DROP;
         cmd_new.data = req_entry_dest;
      end else begin
         cmd_new.op   = lpm_pkg::OP_LOOKUP;
         cmd_new.data = req_lookup_addr;
      end
   end

   assign valid_in = accept || (valid_ff && q_status.full);
   assign cmd_in   = accept ? cmd_new : cmd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

endmodule

@@ rtl/lpm_queue.sv @@
module lpm_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  lpm_pkg::lpm_cmd_type          push_cmd,
   input  logic                          pop,
   output lpm_pkg::lpm_cmd_type          head,
   output lpm_pkg::lpm_q_status_type     q_status
);

   localparam int PTR_W = (lpm_pkg::QUEUE_DEPTH > 1) ? $clog2(lpm_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(lpm_pkg::QUEUE_DEPTH + 1);

   lpm_pkg::lpm_cmd_type  mem_ff [lpm_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  do_push, do_pop;

   assign q_status.full  = count_ff == CNT_W'(lpm_pkg::QUEUE_DEPTH);
   assign q_status.empty = count_ff == '0;
   assign do_push        = push && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign head           = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(lpm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(lpm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ rtl/lpm_back.sv @@
module lpm_back #(
   parameter int TABLE_DEPTH = lpm_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lpm_pkg::lpm_cmd_type          head,
   input  lpm_pkg::lpm_q_status_type     q_status,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic [lpm_pkg::IDX_W-1:0]     rsp_match_index
);

   localparam int SLOTS  = lpm_pkg::slot_count(TABLE_DEPTH);
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int LEVELS = $clog2(SLOTS);
   localparam int PAD    = 1 << LEVELS;
   localparam int LVL_W  = $clog2(LEVELS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_REDUCE,
      ST_FINISH
   } state_type;

   state_type                        state_ff, state_in;
   logic [lpm_pkg::ADDR_W-1:0]       addr_ff, addr_in;
   logic [LVL_W-1:0]                 lvl_ff, lvl_in;
   lpm_pkg::lpm_cand_type            cand_ff [PAD];
   lpm_pkg::lpm_cand_type            cand_in [PAD];
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_hit_ff, rsp_hit_in;
   logic [lpm_pkg::IDX_W-1:0]        rsp_index_ff, rsp_index_in;

   logic [lpm_pkg::ADDR_W-1:0]       route_dest_ff [SLOTS];
   logic [lpm_pkg::ADDR_W-1:0]       route_mask_ff [SLOTS];
   logic [SLOTS-1:0]                 route_valid_ff;

   logic                             out_free;
   logic                             wr_en;

   assign out_free        = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_match_index = rsp_index_ff;

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      lvl_in       = lvl_ff;
      cand_in      = cand_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_hit_in   = rsp_hit_ff;
      rsp_index_in = rsp_index_ff;
      pop          = 1'b0;
      wr_en        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               if (head.op == lpm_pkg::OP_LOOKUP) begin
                  pop      = 1'b1;
                  addr_in  = head.data;
                  state_in = ST_MATCH;
               end else if (out_free) begin
                  // writes and out-of-range writes skip the match and answer with no hit once the output is free
                  pop          = 1'b1;
                  wr_en        = head.op == lpm_pkg::OP_WRITE;
                  rsp_valid_in = 1'b1;
                  rsp_hit_in   = 1'b0;
                  rsp_index_in = '0;
               end
            end
         end
         ST_MATCH: begin
            for (int i = 0; i < PAD; i++) begin
               if (i < SLOTS) begin
                  cand_in[i].valid = route_valid_ff[i] &&
                     (((route_dest_ff[i] ^ addr_ff) & route_mask_ff[i]) == '0);
                  cand_in[i].mask  = route_mask_ff[i];
               end else begin
                  cand_in[i].valid = 1'b0;
                  cand_in[i].mask  = '0;
               end
               cand_in[i].index = lpm_pkg::IDX_W'(i);
            end
            lvl_in   = '0;
            state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            // one tree level per cycle; pairs fold toward slot 0
            for (int i = 0; i < PAD; i++) begin
               if (i < PAD / 2) begin
                  cand_in[i] = lpm_pkg::better(cand_ff[2*i], cand_ff[2*i+1]);
               end else begin
                  cand_in[i].valid = 1'b0;
               end
            end
            if (lvl_ff == LVL_W'(LEVELS - 1)) begin
               state_in = ST_FINISH;
            end else begin
               lvl_in = lvl_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = cand_ff[0].valid;
               rsp_index_in = cand_ff[0].valid ? cand_ff[0].index : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff      <= addr_in;
      lvl_ff       <= lvl_in;
      cand_ff      <= cand_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_index_ff <= rsp_index_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         route_valid_ff <= '0;
      end else if (wr_en) begin
         route_valid_ff[head.index[SLOT_W-1:0]] <= head.valid;
      end
      if (wr_en) begin
         route_dest_ff[head.index[SLOT_W-1:0]] <= head.data;
         route_mask_ff[head.index[SLOT_W-1:0]] <= head.mask;
      end
   end

endmodule

@@ rtl/ipv4_longest_prefix_match.sv @@
// A lookup passes the front register and the queue, then the back end pops it, compares all
// slots in ST_MATCH, folds the candidates in ST_REDUCE and registers the result in ST_FINISH.
// The back end takes no new item until a lookup has left ST_FINISH; the reduction tree folds
// one level per cycle. Writes go one per cycle while the back end is idle and its output is free.
// Reset clears all route valid bits, the queue and the result valid flag; route data is not reset.
module ipv4_longest_prefix_match #(
   parameter int TABLE_DEPTH = lpm_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_type,
   input  logic [lpm_pkg::IDX_W-1:0]     req_entry_index,
   input  logic [lpm_pkg::ADDR_W-1:0]    req_entry_dest,
   input  logic [lpm_pkg::ADDR_W-1:0]    req_entry_mask,
   input  logic                          req_entry_valid,
   input  logic [lpm_pkg::ADDR_W-1:0]    req_lookup_addr,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic [lpm_pkg::IDX_W-1:0]     rsp_match_index
);

   logic                          push;
   logic                          pop;
   lpm_pkg::lpm_cmd_type          push_cmd;
   lpm_pkg::lpm_cmd_type          head;
   lpm_pkg::lpm_q_status_type     q_status;

   lpm_front #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_entry_index (req_entry_index),
      .req_entry_dest  (req_entry_dest),
      .req_entry_mask  (req_entry_mask),
      .req_entry_valid (req_entry_valid),
      .req_lookup_addr (req_lookup_addr),
      .push            (push),
      .push_cmd        (push_cmd),
      .q_status        (q_status)
   );

   lpm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .q_status (q_status)
   );

   lpm_back #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .q_status        (q_status),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_match_index (rsp_match_index)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push && q_status.full))
      else $error("push into full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && q_status.empty))
      else $error("pop from empty queue");

   a_miss_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_match_index == '0))
      else $error("nonzero index on miss");

   a_front_holds_when_full: assert property (@(posedge clock) disable iff (reset)
      (req_stall) |-> q_status.full)
      else $error("front stalls with room in queue");

endmodule
